// ===== rtl/core/gmse_pkg.sv =====
// Shared constants, types and helpers for the grid majority smooth / edge mark block.
// Used by every module under rtl/core; no dependencies of its own.
`default_nettype none

package gmse_pkg;

    // Largest supported frame size
    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;
    localparam int unsigned MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

    // Counter width holds the height plus the two flush rows
    localparam int unsigned CNT_W  = $clog2(MAX_DIM + 3);
    localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);

    // Field widths
    localparam int unsigned CELL_W     = 4;
    localparam int unsigned TDATA_W    = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_MODE    = 2'd2;

    // Pass modes
    localparam logic MODE_SMOOTH = 1'b0;
    localparam logic MODE_MARK   = 1'b1;

    // Cell codes and thresholds
    localparam logic [CELL_W-1:0] CELL_FLOOR = 4'd0;
    localparam logic [CELL_W-1:0] CELL_WALL  = 4'd1;
    localparam logic [3:0]        MAJORITY   = 4'd5;
    localparam logic [2:0]        SIXTH_LAST = 3'd5;
    localparam logic [1:0]        THIRD_LAST = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RESET_SIZE = 11'd24;

    // One cell travelling from the input stage into the line buffer
    typedef struct packed {
        logic              emit;    // this transaction releases a result
        logic              last;    // result is the last cell of the frame
        logic              border;  // result cell lies on the frame border
        logic [CELL_W-1:0] color;   // marking color for the result cell
        logic [CELL_W-1:0] tile;    // value stored into the line buffer
        logic [ADDR_W-1:0] addr;    // line buffer column
    } t_item;

    // Result side flags carried next to the 3x3 window
    typedef struct packed {
        logic              last;
        logic              border;
        logic [CELL_W-1:0] color;
    } t_res;

    // 3x3 window, row-major, oldest row first; center at index 4
    typedef logic [8:0][CELL_W-1:0] t_window;

    // Map a written size onto 1..maxv
    function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v,
                                                    input int unsigned maxv);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (int'(v) > int'(maxv)) begin
            r = CNT_W'(maxv);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gmse_ctrl.sv =====
// Input stage: configuration registers, input/output position counters and color tracking.
// Depends on gmse_pkg.
`default_nettype none

module gmse_ctrl (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [gmse_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [gmse_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                                   i_in_valid,
    input  wire  [gmse_pkg::CELL_W-1:0]           i_cell,
    input  wire                                   i_pad,
    input  wire                                   i_en,
    output logic                                  o_in_ready,
    output logic                                  o_mode,
    output logic                                  o_push,
    output gmse_pkg::t_item                       o_item
);

    localparam int unsigned W = gmse_pkg::CNT_W;

    logic [W-1:0] r_w, r_h;
    logic         r_mode;
    logic [W-1:0] r_in_col, r_in_row, r_out_col, r_out_row;
    logic [W-1:0] n_in_col, n_in_row, n_out_col, n_out_row;
    logic [2:0]   r_col_m6, r_row_m6, n_col_m6, n_row_m6;
    logic [1:0]   r_col_s3, r_row_s3, n_col_s3, n_row_s3;

    logic         accept, drop, in_frame, emit, col_end, row_end, last, border;
    logic         in_col_end, in_row_open;
    logic [2:0]   color_sum, color_mod;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= gmse_pkg::clamp_size(gmse_pkg::RESET_SIZE, gmse_pkg::MAX_WIDTH);
            r_h    <= gmse_pkg::clamp_size(gmse_pkg::RESET_SIZE, gmse_pkg::MAX_HEIGHT);
            r_mode <= gmse_pkg::MODE_SMOOTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gmse_pkg::REG_FRAME_WIDTH:
                    r_w <= gmse_pkg::clamp_size(i_cfg_data, gmse_pkg::MAX_WIDTH);
                gmse_pkg::REG_FRAME_HEIGHT:
                    r_h <= gmse_pkg::clamp_size(i_cfg_data, gmse_pkg::MAX_HEIGHT);
                gmse_pkg::REG_PASS_MODE:
                    r_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Classify the incoming transaction
    always_comb begin
        accept      = i_in_valid && i_en;
        drop        = i_pad && (r_in_row == '0) && (r_in_col == '0);
        in_frame    = r_in_row < r_h;
        emit        = (r_in_row >= W'(2)) || ((r_in_row == W'(1)) && (r_in_col != '0));
        col_end     = ({1'b0, r_out_col} + (W+1)'(1)) >= {1'b0, r_w};
        row_end     = ({1'b0, r_out_row} + (W+1)'(1)) >= {1'b0, r_h};
        last        = col_end && row_end;
        border      = (r_out_col == '0) || (r_out_row == '0) || col_end || row_end;
        in_col_end  = ({1'b0, r_in_col} + (W+1)'(1)) >= {1'b0, r_w};
        in_row_open = {1'b0, r_in_row} < ({1'b0, r_h} + (W+1)'(2));
        color_sum   = {1'b0, r_col_s3} + {1'b0, r_row_s3};
        color_mod   = (color_sum >= 3'd3) ? (color_sum - 3'd3) : color_sum;
    end

    // Advance position counters
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_col_m6  = r_col_m6;
        n_col_s3  = r_col_s3;
        n_row_m6  = r_row_m6;
        n_row_s3  = r_row_s3;
        if (accept && !drop) begin
            if (in_col_end) begin
                n_in_col = '0;
                if (in_row_open) begin
                    n_in_row = r_in_row + W'(1);
                end
            end else begin
                n_in_col = r_in_col + W'(1);
            end
            if (emit) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_col_m6  = '0;
                    n_col_s3  = '0;
                    n_row_m6  = '0;
                    n_row_s3  = '0;
                end else if (col_end) begin
                    n_out_col = '0;
                    n_col_m6  = '0;
                    n_col_s3  = '0;
                    n_out_row = r_out_row + W'(1);
                    if (r_row_m6 == gmse_pkg::SIXTH_LAST) begin
                        n_row_m6 = '0;
                        n_row_s3 = (r_row_s3 == gmse_pkg::THIRD_LAST) ? 2'd0 : r_row_s3 + 2'd1;
                    end else begin
                        n_row_m6 = r_row_m6 + 3'd1;
                    end
                end else begin
                    n_out_col = r_out_col + W'(1);
                    if (r_col_m6 == gmse_pkg::SIXTH_LAST) begin
                        n_col_m6 = '0;
                        n_col_s3 = (r_col_s3 == gmse_pkg::THIRD_LAST) ? 2'd0 : r_col_s3 + 2'd1;
                    end else begin
                        n_col_m6 = r_col_m6 + 3'd1;
                    end
                end
            end
        end
    end

    // Hold counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_col_m6  <= '0;
            r_col_s3  <= '0;
            r_row_m6  <= '0;
            r_row_s3  <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_col_m6  <= n_col_m6;
            r_col_s3  <= n_col_s3;
            r_row_m6  <= n_row_m6;
            r_row_s3  <= n_row_s3;
        end
    end

    // Hand the cell to the line buffer
    always_comb begin
        o_in_ready    = i_en;
        o_mode        = r_mode;
        o_push        = accept && !drop;
        o_item.emit   = emit;
        o_item.last   = last;
        o_item.border = border;
        o_item.color  = gmse_pkg::CELL_W'(color_mod + 3'd1);
        o_item.tile   = (in_frame && !i_pad) ? i_cell : gmse_pkg::CELL_FLOOR;
        o_item.addr   = r_in_col[gmse_pkg::ADDR_W-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/core/gmse_line_buf.sv =====
// Two-line buffer memory with read-modify-write per column and the 3x3 window registers.
// Depends on gmse_pkg.
`default_nettype none

module gmse_line_buf (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_push,
    input  gmse_pkg::t_item            i_item,
    output logic                       o_res_valid,
    output gmse_pkg::t_res             o_res,
    output gmse_pkg::t_window          o_win
);

    localparam int unsigned CW = gmse_pkg::CELL_W;

    // Each entry holds {cell one row back, cell in this row} for one column
    logic [2*CW-1:0]             mem [gmse_pkg::MAX_WIDTH];
    logic [2*CW-1:0]             r_rd, r_fwd_data, rd, wdata;
    logic                        r_fwd;
    logic                        r_b_valid;
    gmse_pkg::t_item             r_b_item;
    gmse_pkg::t_window           r_win;
    logic                        r_c_valid;
    gmse_pkg::t_res              r_c_res;
    logic                        b_step;

    always_comb begin
        b_step = i_en && r_b_valid;
        rd     = r_fwd ? r_fwd_data : r_rd;
        wdata  = {rd[CW-1:0], r_b_item.tile};
    end

    // Write back the column and read the column of the incoming cell
    always_ff @(posedge i_clk) begin
        if (b_step) begin
            mem[r_b_item.addr] <= wdata;
        end
        if (i_en) begin
            r_rd       <= mem[i_item.addr];
            r_fwd_data <= wdata;
        end
    end

    // Forward the write when the read hits the same column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_en) begin
            r_fwd <= r_b_valid && (r_b_item.addr == i_item.addr);
        end
    end

    // Stage B: cell waiting for its column data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= i_push;
            r_c_valid <= r_b_valid && r_b_item.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_item <= i_item;
        end
    end

    // Shift the window by one column
    always_ff @(posedge i_clk) begin
        if (b_step) begin
            r_win[2] <= r_win[1];
            r_win[1] <= r_win[0];
            r_win[0] <= rd[2*CW-1:CW];
            r_win[5] <= r_win[4];
            r_win[4] <= r_win[3];
            r_win[3] <= rd[CW-1:0];
            r_win[8] <= r_win[7];
            r_win[7] <= r_win[6];
            r_win[6] <= r_b_item.tile;
            r_c_res.last   <= r_b_item.last;
            r_c_res.border <= r_b_item.border;
            r_c_res.color  <= r_b_item.color;
        end
    end

    assign o_res_valid = r_c_valid;
    assign o_res       = r_c_res;
    assign o_win       = r_win;

endmodule

`default_nettype wire

// ===== rtl/core/gmse_eval.sv =====
// Window evaluation (majority smoothing or edge marking) and the output register.
// Depends on gmse_pkg.
`default_nettype none

module gmse_eval (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_mode,
    input  wire                              i_res_valid,
    input  gmse_pkg::t_res                   i_res,
    input  gmse_pkg::t_window                i_win,
    input  wire                              i_out_ready,
    output logic                             o_en,
    output logic                             o_out_valid,
    output logic [gmse_pkg::CELL_W-1:0]      o_cell,
    output logic                             o_last
);

    logic [8:0]                  zero_map;
    logic [3:0]                  zeros;
    logic [gmse_pkg::CELL_W-1:0] center, value;
    logic                        out_free, load;
    logic                        r_out_valid, r_out_last;
    logic [gmse_pkg::CELL_W-1:0] r_out_cell;

    // Count floor cells in the window and pick the result
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            zero_map[i] = (i_win[i] == gmse_pkg::CELL_FLOOR);
        end
        zeros  = 4'($countones(zero_map));
        center = i_win[4];
        if (i_res.border) begin
            value = center;
        end else if (i_mode == gmse_pkg::MODE_SMOOTH) begin
            value = (zeros >= gmse_pkg::MAJORITY) ? gmse_pkg::CELL_FLOOR : gmse_pkg::CELL_WALL;
        end else if ((center == gmse_pkg::CELL_WALL) && (zero_map != '0)) begin
            value = i_res.color;
        end else begin
            value = center;
        end
    end

    // Stall the pipe only when a result is stuck behind a full output register
    always_comb begin
        out_free = !r_out_valid || i_out_ready;
        load     = i_res_valid && out_free;
        o_en     = !i_res_valid || out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_cell <= value;
            r_out_last <= i_res.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cell      = r_out_cell;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/grid_majority_smooth_and_edge_mark_top.sv =====
// Grid majority smoothing and edge marking: one 3x3 cellular-automaton pass per frame.
// Top level; depends on gmse_pkg, gmse_ctrl, gmse_line_buf and gmse_eval.
//
// Cells stream in raster order, one per clock, and results leave in raster order one
// row plus one cell behind the input, through stage B, the window registers and the
// output register. The rate of one cell per clock is set by the line buffer, a single
// MAX_WIDTH x 8-bit memory read and written once per cell (two stacked rows per column),
// with forwarding when a cell reads the column that the cell before it is still writing
// (one-column frames and the first cell after a frame). The input stalls only while a
// result waits behind a full output register. No clearing pass after reset. Border cells
// pass through. In smoothing mode an interior cell becomes floor (0) when five or more
// of its nine window cells are floor, else wall (1); in marking mode an interior wall
// touching any floor becomes ((x/6 + y/6) mod 3) + 1. Send frame_width + 1 pad items
// after each frame to flush its last row; a pad at the start of a frame is dropped.
// Write configuration only while the block is idle; the block does not enforce this.
`default_nettype none

module grid_majority_smooth_and_edge_mark_top (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration write port
    input  wire                                   i_cfg_we,
    input  wire  [gmse_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [gmse_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input stream
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [gmse_pkg::TDATA_W-1:0]          s_axis_tdata,  // [3:0] cell_in
    input  wire                                   s_axis_tuser,  // [0] is_pad
    // output stream
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [gmse_pkg::TDATA_W-1:0]          m_axis_tdata,  // [3:0] cell_out
    output logic                                  m_axis_tlast   // frame_last
);

    logic                        en, mode, push, res_valid;
    gmse_pkg::t_item             item;
    gmse_pkg::t_res              res;
    gmse_pkg::t_window           win;
    logic [gmse_pkg::CELL_W-1:0] out_cell;

    gmse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (s_axis_tvalid),
        .i_cell     (s_axis_tdata[gmse_pkg::CELL_W-1:0]),
        .i_pad      (s_axis_tuser),
        .i_en       (en),
        .o_in_ready (s_axis_tready),
        .o_mode     (mode),
        .o_push     (push),
        .o_item     (item)
    );

    gmse_line_buf u_line_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_push      (push),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_win       (win)
    );

    gmse_eval u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (mode),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_win       (win),
        .i_out_ready (m_axis_tready),
        .o_en        (en),
        .o_out_valid (m_axis_tvalid),
        .o_cell      (out_cell),
        .o_last      (m_axis_tlast)
    );

    // Pad the result cell to whole bytes
    assign m_axis_tdata = {{(gmse_pkg::TDATA_W - gmse_pkg::CELL_W){1'b0}}, out_cell};

endmodule

`default_nettype wire
